/* src/assert_macros.svh */
// Assertion macros shared by the RTL. All of them sample on clk and are
// disabled while rst_n is low, so they may only be used in modules with
// those two ports.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_ALWAYS(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("%m: assertion failed");

`define ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: assertion failed");

`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`else

`define ASSERT_ALWAYS(label, expr)

`define ASSERT_IMPLIES(label, ante, cons)

`define ASSERT_NEXT(label, ante, cons)

`endif

`endif

/* src/spq_pkg.sv */
`default_nettype none

package spq_pkg;

    localparam int CAPACITY = 16;
    localparam int PRI_W    = 8;
    localparam int MSG_W    = 32;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int OCC_W    = 5;

    typedef logic [PRI_W-1:0] pri_t;
    typedef logic [MSG_W-1:0] msg_t;
    typedef logic [CNT_W-1:0] cnt_t;
    typedef logic [OCC_W-1:0] occ_t;

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_REMOVE = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // Operation applied to the slot array.
    typedef struct packed {
        logic insert;
        logic remove;
        pri_t pri;
        msg_t msg;
    } slot_op_t;

    // What the slot array reports back before the operation is applied.
    typedef struct packed {
        cnt_t count;
        logic full;
        logic empty;
        msg_t head_msg;
    } slot_stat_t;

endpackage

`default_nettype wire

/* src/spq_if.sv */
`default_nettype none

interface spq_req_if;
    import spq_pkg::*;

    logic valid;
    logic ready;
    logic cmd;
    pri_t priority_req;
    msg_t message;

    modport source (output valid, output cmd, output priority_req, output message,
                    input ready);
    modport sink   (input valid, input cmd, input priority_req, input message,
                    output ready);
endinterface

interface spq_rsp_if;
    import spq_pkg::*;

    logic           valid;
    logic           ready;
    msg_t           out_message;
    logic [1:0]     status;
    occ_t           occupancy;

    modport source (output valid, output out_message, output status, output occupancy,
                    input ready);
    modport sink   (input valid, input out_message, input status, input occupancy,
                    output ready);
endinterface

`default_nettype wire

/* src/spq_slot_array.sv */
`default_nettype none

`include "assert_macros.svh"

module spq_slot_array (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire spq_pkg::slot_op_t  op,
    output spq_pkg::slot_stat_t     stat
);
    import spq_pkg::*;

    pri_t slot_pri_reg  [CAPACITY];
    msg_t slot_msg_reg  [CAPACITY];
    pri_t slot_pri_next [CAPACITY];
    msg_t slot_msg_next [CAPACITY];
    cnt_t count_reg;
    cnt_t count_next;
    logic [CAPACITY-1:0] keep;

    // Slots are sorted with slot 0 as the head. An entry stays in place on
    // insert when it is occupied and its priority is not below the new one;
    // since the array is sorted, these slots form a prefix.
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            keep[i] = (CNT_W'(i) < count_reg) && (slot_pri_reg[i] >= op.pri);
        end
    end

    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            slot_pri_next[i] = slot_pri_reg[i];
            slot_msg_next[i] = slot_msg_reg[i];
            if (op.insert && !keep[i])
            begin
                if (i == 0 || keep[(i == 0) ? 0 : i - 1])
                begin
                    slot_pri_next[i] = op.pri;
                    slot_msg_next[i] = op.msg;
                end
                else
                begin
                    slot_pri_next[i] = slot_pri_reg[(i == 0) ? 0 : i - 1];
                    slot_msg_next[i] = slot_msg_reg[(i == 0) ? 0 : i - 1];
                end
            end
            else if (op.remove && i < CAPACITY - 1)
            begin
                slot_pri_next[i] = slot_pri_reg[(i < CAPACITY - 1) ? i + 1 : i];
                slot_msg_next[i] = slot_msg_reg[(i < CAPACITY - 1) ? i + 1 : i];
            end
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (op.insert)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (op.remove)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            slot_pri_reg[i] <= slot_pri_next[i];
            slot_msg_reg[i] <= slot_msg_next[i];
        end
    end

    assign stat.count    = count_reg;
    assign stat.full     = (count_reg == CNT_W'(CAPACITY));
    assign stat.empty    = (count_reg == '0);
    assign stat.head_msg = slot_msg_reg[0];

    `ASSERT_ALWAYS(a_count_bound, count_reg <= CNT_W'(CAPACITY))
    `ASSERT_ALWAYS(a_single_op, !(op.insert && op.remove))
    `ASSERT_IMPLIES(a_no_insert_full, op.insert, count_reg != CNT_W'(CAPACITY))
    `ASSERT_NEXT(a_remove_dec, op.remove, count_reg == $past(count_reg) - 1'b1)
    `ASSERT_NEXT(a_first_is_head, op.insert && count_reg == '0, slot_msg_reg[0] == $past(op.msg))

endmodule

`default_nettype wire

/* src/stable_priority_queue.sv */
`default_nettype none

// Bounded priority queue of message handles with 16 slots. Each request is
// either an insert (cmd 0) or a remove of the head (cmd 1) and yields exactly
// one response carrying the removed handle (zero unless a remove succeeded),
// a status (ok, empty on remove, full on insert) and the occupancy after the
// request. Higher priorities leave first; equal priorities leave in arrival
// order. One request is accepted per cycle while the input is not stalled:
// it is captured in an input register, and once the response register is free
// or being taken, all slots compare against it in parallel, shift in one step
// and the response is registered and held until it is taken. While a finished
// response waits to be taken, one more request can be held in the input
// register; after that the input stalls until the response is taken.

`include "assert_macros.svh"

module stable_priority_queue (
    input  wire logic  clk,
    input  wire logic  rst_n,
    spq_req_if.sink    req,
    spq_rsp_if.source  rsp
);
    import spq_pkg::*;

    logic       in_vld_reg;
    logic       in_cmd_reg;
    pri_t       in_pri_reg;
    msg_t       in_msg_reg;

    logic       rsp_vld_reg;
    logic       rsp_vld_next;
    msg_t       rsp_msg_reg;
    msg_t       rsp_msg_next;
    status_t    rsp_status_reg;
    status_t    rsp_status_next;
    occ_t       rsp_occ_reg;
    occ_t       rsp_occ_next;

    logic       advance;
    slot_op_t   op;
    slot_stat_t stat;
    cnt_t       count_after;

    assign advance   = in_vld_reg && (!rsp_vld_reg || rsp.ready);
    assign req.ready = !in_vld_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            in_vld_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.ready && req.valid)
        begin
            in_cmd_reg <= req.cmd;
            in_pri_reg <= req.priority_req;
            in_msg_reg <= req.message;
        end
    end

    always_comb
    begin
        op.insert = advance && (in_cmd_reg == CMD_INSERT) && !stat.full;
        op.remove = advance && (in_cmd_reg == CMD_REMOVE) && !stat.empty;
        op.pri    = in_pri_reg;
        op.msg    = in_msg_reg;
    end

    spq_slot_array u_slots (
        .clk   (clk),
        .rst_n (rst_n),
        .op    (op),
        .stat  (stat)
    );

    always_comb
    begin
        count_after = stat.count;
        if (op.insert)
        begin
            count_after = stat.count + 1'b1;
        end
        else if (op.remove)
        begin
            count_after = stat.count - 1'b1;
        end

        rsp_msg_next    = op.remove ? stat.head_msg : '0;
        rsp_occ_next    = OCC_W'(count_after);
        rsp_status_next = ST_OK;
        if (in_cmd_reg == CMD_INSERT && stat.full)
        begin
            rsp_status_next = ST_FULL;
        end
        else if (in_cmd_reg == CMD_REMOVE && stat.empty)
        begin
            rsp_status_next = ST_EMPTY;
        end

        rsp_vld_next = rsp_vld_reg;
        if (advance)
        begin
            rsp_vld_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_vld_reg <= 1'b0;
        end
        else
        begin
            rsp_vld_reg <= rsp_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rsp_msg_reg    <= rsp_msg_next;
            rsp_status_reg <= rsp_status_next;
            rsp_occ_reg    <= rsp_occ_next;
        end
    end

    assign rsp.valid       = rsp_vld_reg;
    assign rsp.out_message = rsp_msg_reg;
    assign rsp.status      = rsp_status_reg;
    assign rsp.occupancy   = rsp_occ_reg;

    `ASSERT_IMPLIES(a_full_occ, rsp_vld_reg && rsp_status_reg == ST_FULL,
                    rsp_occ_reg == OCC_W'(CAPACITY))
    `ASSERT_IMPLIES(a_empty_zero, rsp_vld_reg && rsp_status_reg == ST_EMPTY,
                    rsp_occ_reg == '0 && rsp_msg_reg == '0)
    `ASSERT_IMPLIES(a_idle_ready, !in_vld_reg, req.ready)
    `ASSERT_NEXT(a_advance_rsp, advance, rsp_vld_reg)

endmodule

`default_nettype wire
